@@ rtl/rpn_pkg.sv @@
// ----------------------------------------------------------------------------
// RPN evaluator package
// Token kinds, status codes, controller states and the command/status
// structs shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package rpn_pkg;

  // Default stack depth
  localparam int STACK_DEPTH_DEF = 16;

  // Data word width
  localparam int WORD_W = 32;

  // Input digit width
  localparam int DIGIT_W = 5;

  // Token kinds; code seven has no meaning and is handled as a bad token
  typedef enum logic [2:0] {
    K_NUM  = 3'd0,
    K_ADD  = 3'd1,
    K_SUB  = 3'd2,
    K_MUL  = 3'd3,
    K_DIV  = 3'd4,
    K_END  = 3'd5,
    K_BAD  = 3'd6
  } kind_t;

  // Result status codes
  typedef enum logic [2:0] {
    S_OK       = 3'd0,
    S_UNDER    = 3'd1,
    S_BADTOK   = 3'd2,
    S_LEFTOVER = 3'd3,
    S_DIVZERO  = 3'd4,
    S_OVER     = 3'd5
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DIV,
    ST_END_WAIT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    push;
    logic    alu_wr;
    logic    div_start;
    logic    div_wr;
    logic    err_set;
    status_t err_code;
    logic    out_load;
    kind_t   op;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic count_lt2;
    logic full;
    logic top_zero;
    logic err_pending;
    logic out_free;
    logic div_done;
  } dp_stat_t;

endpackage

@@ rtl/rpn_div.sv @@
// ----------------------------------------------------------------------------
// RPN signed divider
// Restoring divider on magnitudes, one quotient bit per cycle, signed
// quotient truncated toward zero and wrapped to 32 bits.
// ----------------------------------------------------------------------------
module rpn_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [rpn_pkg::WORD_W-1:0] num,
  input  logic [rpn_pkg::WORD_W-1:0] den,
  output logic                      done,
  output logic [rpn_pkg::WORD_W-1:0] quotient
);
  import rpn_pkg::*;

  localparam int CNT_W = $clog2(WORD_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic              neg;
  logic [WORD_W-1:0] ud;
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] quo;
  logic [WORD_W:0]   shifted;
  logic              ge;

  // Trial subtraction of one step
  assign shifted = {rem, quo[WORD_W-1]};
  assign ge      = shifted >= {1'b0, ud};

  // Control: busy for WORD_W steps, then a done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operand magnitudes and shift register
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num[WORD_W-1] ^ den[WORD_W-1];
      ud  <= den[WORD_W-1] ? (~den + 1'b1) : den;
      quo <= num[WORD_W-1] ? (~num + 1'b1) : num;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? WORD_W'(shifted - {1'b0, ud}) : shifted[WORD_W-1:0];
      quo <= {quo[WORD_W-2:0], ge};
    end
  end

  // Sign fix
  assign quotient = neg ? (~quo + 1'b1) : quo;

endmodule

@@ rtl/rpn_dpath.sv @@
// ----------------------------------------------------------------------------
// RPN datapath
// Operand stack (top in a register, the rest in a memory), count, sticky
// error, add/subtract/multiply unit, divider and the result register.
// ----------------------------------------------------------------------------
module rpn_dpath #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  rpn_pkg::dp_cmd_t            cmd,
  output rpn_pkg::dp_stat_t           stat,
  input  logic [rpn_pkg::DIGIT_W-1:0] digit,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [rpn_pkg::WORD_W-1:0]  m_tdata,
  output logic [2:0]                  m_tuser
);
  import rpn_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [WORD_W-1:0] mem [STACK_DEPTH];
  logic [WORD_W-1:0] rd_q;
  logic [WORD_W-1:0] top;
  logic [CW-1:0]     count;
  status_t           err;
  logic [CW-1:0]     wr_ptr;
  logic [CW-1:0]     rd_ptr;
  logic [WORD_W-1:0] alu_r;
  logic              div_done;
  logic [WORD_W-1:0] div_q;
  status_t           res_status;
  logic [WORD_W-1:0] res_answer;

  // A push writes the old top at count-1; the second operand is read from count-2
  assign wr_ptr = count - 1'b1;
  assign rd_ptr = count - CW'(2);

  // Stack memory below the top entry
  always_ff @(posedge clk) begin
    if (cmd.push && count != '0) begin
      mem[wr_ptr[AW-1:0]] <= top;
    end
  end

  always_ff @(posedge clk) begin
    rd_q <= mem[rd_ptr[AW-1:0]];
  end

  // Add, subtract, multiply on second (memory) and top
  always_comb begin
    case (cmd.op)
      K_ADD:   alu_r = rd_q + top;
      K_SUB:   alu_r = rd_q - top;
      K_MUL:   alu_r = rd_q * top;
      default: alu_r = rd_q + top;
    endcase
  end

  rpn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .num      (rd_q),
    .den      (top),
    .done     (div_done),
    .quotient (div_q)
  );

  // Top register
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      top <= {{(WORD_W - DIGIT_W){digit[DIGIT_W-1]}}, digit};
    end else if (cmd.alu_wr) begin
      top <= alu_r;
    end else if (cmd.div_wr) begin
      top <= div_q;
    end
  end

  // Count and sticky error
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      err   <= S_OK;
    end else begin
      if (cmd.out_load) begin
        count <= '0;
        err   <= S_OK;
      end else begin
        if (cmd.push) begin
          count <= count + 1'b1;
        end else if (cmd.alu_wr || cmd.div_wr) begin
          count <= count - 1'b1;
        end
        if (cmd.err_set) begin
          err <= cmd.err_code;
        end
      end
    end
  end

  // End-of-expression result
  always_comb begin
    res_answer = '0;
    if (err != S_OK) begin
      res_status = err;
    end else if (count == '0) begin
      res_status = S_UNDER;
    end else if (count != CW'(1)) begin
      res_status = S_LEFTOVER;
    end else begin
      res_status = S_OK;
      res_answer = top;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= res_answer;
      m_tuser <= res_status;
    end
  end

  // Status to the controller
  assign stat.count_lt2   = count < CW'(2);
  assign stat.full        = count == CW'(STACK_DEPTH);
  assign stat.top_zero    = top == '0;
  assign stat.err_pending = err != S_OK;
  assign stat.out_free    = !m_tvalid || m_tready;
  assign stat.div_done    = div_done;

endmodule

@@ rtl/rpn_ctrl.sv @@
// ----------------------------------------------------------------------------
// RPN controller
// Decodes each token request, checks error conditions and sequences the
// datapath through operand fetch, divide and result output.
// ----------------------------------------------------------------------------
module rpn_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [2:0]                  kind,
  input  logic [rpn_pkg::DIGIT_W-1:0] digit,
  input  rpn_pkg::dp_stat_t           stat,
  output rpn_pkg::dp_cmd_t            cmd
);
  import rpn_pkg::*;

  state_t state;
  state_t state_next;
  kind_t  op;
  logic   accept;
  logic   digit_ok;

  assign accept   = s_tvalid && (state == ST_IDLE);
  assign digit_ok = ($signed(digit) >= -5'sd9) && ($signed(digit) <= 5'sd9);

  // State and latched operator
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= K_ADD;
    end else begin
      state <= state_next;
      if (accept) begin
        op <= kind_t'(kind);
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (kind == K_END) begin
            if (!stat.out_free) state_next = ST_END_WAIT;
          end else if (!stat.err_pending) begin
            if ((kind == K_ADD || kind == K_SUB || kind == K_MUL) && !stat.count_lt2) begin
              state_next = ST_FETCH;
            end else if (kind == K_DIV && !stat.count_lt2 && !stat.top_zero) begin
              state_next = ST_FETCH;
            end
          end
        end
      end
      ST_FETCH: begin
        state_next = (op == K_DIV) ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (stat.div_done) state_next = ST_IDLE;
      end
      ST_END_WAIT: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd          = '0;
    cmd.err_code = S_OK;
    cmd.op       = op;
    s_tready     = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (kind == K_END) begin
            cmd.out_load = stat.out_free;
          end else if (!stat.err_pending) begin
            case (kind)
              K_NUM: begin
                if (!digit_ok) begin
                  cmd.err_set  = 1'b1;
                  cmd.err_code = S_BADTOK;
                end else if (stat.full) begin
                  cmd.err_set  = 1'b1;
                  cmd.err_code = S_OVER;
                end else begin
                  cmd.push = 1'b1;
                end
              end
              K_ADD, K_SUB, K_MUL: begin
                if (stat.count_lt2) begin
                  cmd.err_set  = 1'b1;
                  cmd.err_code = S_UNDER;
                end
              end
              K_DIV: begin
                if (stat.count_lt2) begin
                  cmd.err_set  = 1'b1;
                  cmd.err_code = S_UNDER;
                end else if (stat.top_zero) begin
                  cmd.err_set  = 1'b1;
                  cmd.err_code = S_DIVZERO;
                end
              end
              default: begin
                cmd.err_set  = 1'b1;
                cmd.err_code = S_BADTOK;
              end
            endcase
          end
        end
      end
      ST_FETCH: begin
        if (op == K_DIV) cmd.div_start = 1'b1;
        else             cmd.alu_wr    = 1'b1;
      end
      ST_DIV: begin
        cmd.div_wr = stat.div_done;
      end
      ST_END_WAIT: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
        cmd.op = op;
      end
    endcase
  end

endmodule

@@ rtl/rpn_stack_evaluator.sv @@
// ----------------------------------------------------------------------------
// RPN stack evaluator
// Evaluates a reverse Polish expression one token request at a time and
// returns one result request per end token.
//
//   Channel  Dir  tdata (low bit up)         tuser (low bit up)
//   s_*      in   digit_value[4:0], 0 pad    kind[2:0]
//   m_*      out  answer[31:0]               status[2:0]
//
// A number, error or ignored token is handled in the idle state alone; add,
// subtract and multiply go through a stack memory read, then execute; divide
// goes through the read, then the one-bit-per-cycle divider. An end token waits
// only while a previous result still waits in the output register.
// Reset clears the count and error; the stack memory is not cleared.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // digit_value[4:0], zero pad
  input  logic [2:0]                 s_tuser,   // kind[2:0]
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [rpn_pkg::WORD_W-1:0] m_tdata,   // answer[31:0]
  output logic [2:0]                 m_tuser    // status[2:0]
);
  import rpn_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rpn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .kind     (s_tuser),
    .digit    (s_tdata[DIGIT_W-1:0]),
    .stat     (stat),
    .cmd      (cmd)
  );

  rpn_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .digit    (s_tdata[DIGIT_W-1:0]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

@@ test/rpn_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RPN evaluator checker
// Watches both stream channels of the evaluator. Every accepted token request
// is run through a local model of the operand stack; each end token queues
// the status and answer it must produce. Result requests are matched in order
// against that queue, field by field.
// ----------------------------------------------------------------------------
module rpn_checker #(
  parameter int DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [7:0]                 s_tdata,    // digit_value[4:0], zero pad
  input  logic [2:0]                 s_tuser,    // kind[2:0]
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [rpn_pkg::WORD_W-1:0] m_tdata,    // answer[31:0]
  input  logic [2:0]                 m_tuser,    // status[2:0]
  output int                         mismatches,
  output int                         pending_results,
  output int                         tokens_seen,
  output int                         results_seen,
  output int                         error_reports
);
  import rpn_pkg::*;

  typedef struct packed {
    status_t           status;
    logic [WORD_W-1:0] answer;
  } outcome_t;

  outcome_t          outcome_q[$];
  logic [WORD_W-1:0] operands[DEPTH];
  int                live_count;
  status_t           first_error;
  int                n_fail;
  int                n_tokens;
  int                n_results;
  int                n_errors;

  // Signed divide truncating toward zero, built on magnitudes so the most
  // negative value over minus one wraps instead of trapping
  function automatic logic [WORD_W-1:0] trunc_quotient(input logic [WORD_W-1:0] num,
                                                       input logic [WORD_W-1:0] den);
    logic [WORD_W-1:0] mag_n;
    logic [WORD_W-1:0] mag_d;
    logic [WORD_W-1:0] q;
    mag_n = num[WORD_W-1] ? 32'd0 - num : num;
    mag_d = den[WORD_W-1] ? 32'd0 - den : den;
    q = mag_n / mag_d;
    return (num[WORD_W-1] ^ den[WORD_W-1]) ? 32'd0 - q : q;
  endfunction

  // Advance the stack model by one token; end tokens queue an outcome
  task automatic apply_token(input logic [2:0] kind, input logic [DIGIT_W-1:0] digit);
    logic [WORD_W-1:0] top;
    logic [WORD_W-1:0] second;
    logic [WORD_W-1:0] r;
    outcome_t          o;
    if (kind == K_END) begin
      o.status = first_error;
      o.answer = '0;
      if (first_error == S_OK) begin
        if (live_count == 0) o.status = S_UNDER;
        else if (live_count > 1) o.status = S_LEFTOVER;
        else o.answer = operands[0];
      end
      outcome_q.push_back(o);
      live_count = 0;
      first_error = S_OK;
    end else if (first_error != S_OK) begin
      // sticky error: token dropped
    end else if (kind == K_NUM) begin
      if ($signed(digit) < -9 || $signed(digit) > 9) first_error = S_BADTOK;
      else if (live_count >= DEPTH) first_error = S_OVER;
      else begin
        operands[live_count] = {{(WORD_W-DIGIT_W){digit[DIGIT_W-1]}}, digit};
        live_count++;
      end
    end else if (kind >= K_ADD && kind <= K_DIV) begin
      if (live_count < 2) first_error = S_UNDER;
      else begin
        top = operands[live_count-1];
        second = operands[live_count-2];
        if (kind == K_DIV && top == '0) first_error = S_DIVZERO;
        else begin
          case (kind)
            K_ADD:   r = second + top;
            K_SUB:   r = second - top;
            K_MUL:   r = second * top;
            default: r = trunc_quotient(second, top);
          endcase
          live_count--;
          operands[live_count-1] = r;
        end
      end
    end else begin
      // invalid token code, including the unused one
      first_error = S_BADTOK;
    end
  endtask

  // Match one result request against the oldest queued outcome
  task automatic check_result(input logic [2:0] status, input logic [WORD_W-1:0] answer);
    outcome_t o;
    n_results++;
    if (status != S_OK) n_errors++;
    if (outcome_q.size() == 0) begin
      if (n_fail < 10)
        $display("ERROR: unexpected result status %0d answer %0d", status, $signed(answer));
      n_fail++;
    end else begin
      o = outcome_q.pop_front();
      if (status !== o.status || answer !== o.answer) begin
        if (n_fail < 10)
          $display("ERROR: result %0d: status exp %0d got %0d, answer exp %0d got %0d",
                   n_results, o.status, status, $signed(o.answer), $signed(answer));
        n_fail++;
      end
    end
  endtask

  // Monitor: outputs first so a result never pairs with a token of the same edge
  always @(posedge clk) begin
    if (rst) begin
      outcome_q.delete();
      live_count = 0;
      first_error = S_OK;
    end else begin
      if (m_tvalid && m_tready) check_result(m_tuser, m_tdata);
      if (s_tvalid && s_tready) begin
        apply_token(s_tuser, s_tdata[DIGIT_W-1:0]);
        n_tokens++;
      end
    end
    mismatches      <= n_fail;
    pending_results <= outcome_q.size();
    tokens_seen     <= n_tokens;
    results_seen    <= n_results;
    error_reports   <= n_errors;
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RPN evaluator testbench
// Drives token requests into the evaluator: a short directed list, then
// random expressions (mostly well formed, some deep, some building the most
// negative word, some broken or pure noise). Both channels idle at random.
// The checker alongside predicts and compares every result request.
// ----------------------------------------------------------------------------
module tb;
  import rpn_pkg::*;

  localparam int          DEPTH      = STACK_DEPTH_DEF;
  localparam int          HALF_CLK   = 2;
  localparam int          ITEM_GOAL  = 1700;
  localparam int          DRAIN_CYC  = 64;
  localparam logic [4:0]  MINUS_ONE  = 5'h1F;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata  = '0;
  logic [2:0]        s_tuser  = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [WORD_W-1:0] m_tdata;
  logic [2:0]        m_tuser;

  int mismatches;
  int pending_results;
  int tokens_seen;
  int results_seen;
  int error_reports;

  bit calm = 1'b0;
  int stall_left = 0;
  int driven_items = 0;
  int deep_runs = 0;
  int chain_runs = 0;

  always #(HALF_CLK) clk = ~clk;

  rpn_stack_evaluator i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  rpn_checker #(.DEPTH(DEPTH)) i_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .mismatches      (mismatches),
    .pending_results (pending_results),
    .tokens_seen     (tokens_seen),
    .results_seen    (results_seen),
    .error_reports   (error_reports)
  );

  // Idle length: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [4:0] rand_digit();
    int v;
    v = $urandom_range(0, 18) - 9;
    return v[4:0];
  endfunction

  function automatic logic [4:0] rand_bits();
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic kind_t rand_op();
    case ($urandom_range(0, 3))
      0:       return K_ADD;
      1:       return K_SUB;
      2:       return K_MUL;
      default: return K_DIV;
    endcase
  endfunction

  // Result side back-pressure
  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      m_tready <= 1'b0;
      stall_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                 : $urandom_range(8, 40);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // One token request; tvalid stays high after acceptance unless a gap follows
  task automatic send_token(input logic [2:0] kind, input logic [4:0] digit,
                            input bit counted);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {3'b000, digit};
    do @(posedge clk); while (!s_tready);
    if (counted) driven_items++;
  endtask

  // Random well-formed body with the given number of operands, no end token
  task automatic well_formed(input int leaves);
    int live;
    int left;
    live = 0;
    left = leaves;
    while (left > 0 || live > 1) begin
      if (live < 2 || (left > 0 && live < DEPTH && $urandom_range(0, 1) == 1)) begin
        send_token(K_NUM, rand_digit(), 1'b1);
        left--;
        live++;
      end else begin
        send_token(rand_op(), rand_bits(), 1'b1);
        live--;
      end
    end
  endtask

  // Fill the stack to the top, then either collapse it or push past the top
  task automatic deep_stack(input bit overflow);
    deep_runs++;
    repeat (DEPTH) send_token(K_NUM, rand_digit(), 1'b1);
    if (overflow) begin
      send_token(K_NUM, rand_digit(), 1'b1);
      repeat ($urandom_range(0, 3)) send_token(rand_op(), rand_bits(), 1'b0);
    end else begin
      repeat (DEPTH - 1) send_token(rand_op(), rand_bits(), 1'b1);
    end
    send_token(K_END, rand_bits(), 1'b1);
  endtask

  // Multiply signed powers of two up to 2^31, which wraps to the most negative
  // word, then divide or combine it with minus one / one
  task automatic power_chain();
    int         left;
    int         e;
    bit         first;
    logic [4:0] f;
    chain_runs++;
    left = 31;
    first = 1'b1;
    while (left > 0) begin
      e = $urandom_range(1, (left < 3) ? left : 3);
      f = 5'(1 << e);
      if ($urandom_range(0, 1) == 1) f = -f;
      send_token(K_NUM, f, 1'b1);
      if (!first) send_token(K_MUL, rand_bits(), 1'b1);
      first = 1'b0;
      left -= e;
    end
    case ($urandom_range(0, 3))
      0, 1: begin
        send_token(K_NUM, MINUS_ONE, 1'b1);
        send_token(K_DIV, rand_bits(), 1'b1);
      end
      2: begin
        send_token(K_NUM, MINUS_ONE, 1'b1);
        send_token(K_MUL, rand_bits(), 1'b1);
      end
      default: begin
        send_token(K_NUM, 5'd1, 1'b1);
        send_token(K_SUB, rand_bits(), 1'b1);
      end
    endcase
    send_token(K_END, rand_bits(), 1'b1);
  endtask

  // Stimulus
  initial begin
    int         pick;
    int         v;
    logic [4:0] d;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty end, extremes of the digit, every operator with
    // truncating division, divide by zero, operator underflow, leftover
    // operands, sticky bad token, out-of-range digit
    send_token(K_END, 5'd0, 1'b1);
    send_token(K_NUM, 5'd9, 1'b1);
    send_token(K_NUM, 5'h17, 1'b1);
    send_token(K_SUB, 5'd0, 1'b1);
    send_token(K_END, 5'd0, 1'b1);
    send_token(K_NUM, 5'd7, 1'b1);
    send_token(K_NUM, 5'h1D, 1'b1);
    send_token(K_DIV, 5'd0, 1'b1);
    send_token(K_NUM, 5'd5, 1'b1);
    send_token(K_ADD, 5'd0, 1'b1);
    send_token(K_NUM, 5'd3, 1'b1);
    send_token(K_MUL, 5'd0, 1'b1);
    send_token(K_END, 5'd0, 1'b1);
    send_token(K_NUM, 5'd4, 1'b1);
    send_token(K_NUM, 5'd0, 1'b1);
    send_token(K_DIV, 5'd0, 1'b1);
    send_token(K_END, 5'd0, 1'b1);
    send_token(K_ADD, 5'd0, 1'b1);
    send_token(K_END, 5'd0, 1'b1);
    send_token(K_NUM, 5'd1, 1'b1);
    send_token(K_NUM, 5'd2, 1'b1);
    send_token(K_END, 5'd0, 1'b1);
    send_token(3'd7, 5'd0, 1'b1);
    send_token(K_NUM, 5'd3, 1'b0);
    send_token(K_NUM, 5'd0, 1'b0);
    send_token(K_DIV, 5'd0, 1'b0);
    send_token(K_END, 5'd0, 1'b1);
    send_token(K_NUM, 5'd15, 1'b1);
    send_token(K_END, 5'd0, 1'b1);

    // Overflow and the most negative word first, then the random mix
    deep_stack(1'b1);
    power_chain();
    while (driven_items < ITEM_GOAL) begin
      if ($urandom_range(0, 99) < 15) calm = ~calm;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        well_formed(($urandom_range(0, 9) == 0) ? $urandom_range(9, DEPTH)
                                                : $urandom_range(1, 8));
        send_token(K_END, rand_bits(), 1'b1);
      end else if (pick < 63) begin
        deep_stack(1'($urandom_range(0, 1)));
      end else if (pick < 70) begin
        power_chain();
      end else if (pick < 84) begin
        // broken expression: valid prefix, one error, ignored tail
        well_formed($urandom_range(1, 4));
        case ($urandom_range(0, 3))
          0: send_token($urandom_range(0, 1) ? K_BAD : 3'd7, rand_bits(), 1'b1);
          1: begin
            v = $urandom_range(0, 1) ? $urandom_range(10, 15) : -$urandom_range(10, 16);
            send_token(K_NUM, v[4:0], 1'b1);
          end
          2: send_token(rand_op(), rand_bits(), 1'b1);
          default: begin
            send_token(K_NUM, 5'd0, 1'b1);
            send_token(K_DIV, rand_bits(), 1'b1);
          end
        endcase
        repeat ($urandom_range(0, 6)) begin
          d = rand_bits();
          send_token(3'($urandom_range(0, 4)), d, 1'b0);
        end
        send_token(K_END, rand_bits(), 1'b1);
      end else if (pick < 93) begin
        // leftover operands, or an end with nothing pushed
        if ($urandom_range(0, 3) != 0) begin
          repeat ($urandom_range(2, 5)) send_token(K_NUM, rand_digit(), 1'b1);
          if ($urandom_range(0, 1) == 1) send_token(rand_op(), rand_bits(), 1'b1);
        end
        send_token(K_END, rand_bits(), 1'b1);
      end else begin
        // noise: any code with any digit bits
        repeat ($urandom_range(1, 10)) send_token(3'($urandom_range(0, 7)), rand_bits(), 1'b1);
        send_token(K_END, rand_bits(), 1'b1);
      end
    end
    s_tvalid <= 1'b0;
    calm = 1'b0;

    // Drain
    do @(posedge clk); while (pending_results != 0);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Covered %0d token requests (%0d full-stack runs, %0d most-negative chains)",
             tokens_seen, deep_runs, chain_runs);
    $display("Checked %0d result requests, %0d of them error reports, %0d mismatches",
             results_seen, error_reports, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("Timeout waiting for the evaluator");
    $display("Test completed with failures");
    $finish;
  end

endmodule
